### src/mpf_pkg.sv
package mpf_pkg;

  localparam int PANEL_WIDTH  = 128;
  localparam int PANEL_HEIGHT = 64;
  localparam int PAGE_ROWS    = 8;
  localparam int STORE_BYTES  = PANEL_WIDTH * ((PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
  localparam int ADDR_W       = $clog2(STORE_BYTES);

  localparam int REQ_W   = 2;
  localparam int COORD_W = 8;
  localparam int BIDX_W  = 10;
  localparam int BYTE_W  = 8;
  localparam int S_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [BYTE_W-1:0] FILL_SET   = 8'hFF;
  localparam logic [BYTE_W-1:0] FILL_CLEAR = 8'h00;

  typedef enum logic [REQ_W-1:0] {
    REQ_DRAW   = 2'd0,
    REQ_INVERT = 2'd1,
    REQ_FILL   = 2'd2,
    REQ_READ   = 2'd3
  } req_type_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_FLIP_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 1'd1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

endpackage

### src/monochrome_page_framebuffer.sv
// Channel    | Group                      | Contents (lowest bit first)
// -----------+----------------------------+---------------------------------------------
// request    | s_tvalid s_tready s_tdata  | tuser: req_type; tdata: pixel_x, pixel_y,
//            | s_tuser                    |   pixel_colour, byte_index, zero padding
// result     | m_tvalid m_tready m_tdata  | tuser: status; tdata: read_data
//            | m_tuser                    |
// config     | cfg_write cfg_index        | index 0 flip_mode, index 1 background_colour
//            | cfg_data                   |
//
// Draw, invert and read requests go from acceptance to a valid result through the steps
// locate, memory read, modify or capture, and respond, in that order.
// A pixel outside the panel skips the memory steps and goes from locate to respond.
// A fill sweeps the store one byte per cycle.
// After reset, clearing all STORE_BYTES (1024) bytes runs before s_tready rises.
// One request is worked on at a time; the next may be accepted while a result waits on
// m_tready; the sequencer then stays in its respond step until that result is taken.
module monochrome_page_framebuffer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // pixel_x [7:0], pixel_y [15:8], pixel_colour [16], byte_index [26:17], zeros above
  input  logic [mpf_pkg::S_DATA_W-1:0]  s_tdata,
  // req_type [1:0]
  input  logic [mpf_pkg::REQ_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // read_data [7:0]
  output logic [mpf_pkg::BYTE_W-1:0]    m_tdata,
  // status [0]
  output logic                          m_tuser,
  input  logic                          cfg_write,
  input  logic [mpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                          cfg_data
);
  import mpf_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_LOCATE = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_MODIFY = 7'b0010000,
    ST_SWEEP  = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] WIDTH_A  = ADDR_W'(PANEL_WIDTH);

  state_t state, state_next;

  logic flip_mode;
  logic background_colour;

  req_type_t            req;
  logic [COORD_W-1:0]   pixel_x;
  logic [COORD_W-1:0]   pixel_y;
  logic                 pixel_colour;
  logic [BIDX_W-1:0]    byte_index;

  logic [ADDR_W-1:0]    addr;
  logic [BYTE_W-1:0]    mask;
  logic [BYTE_W-1:0]    fill_byte;
  logic                 status;
  logic [BYTE_W-1:0]    result_data;

  logic [BYTE_W-1:0]    frame_store [STORE_BYTES];
  logic [BYTE_W-1:0]    mem_rdata;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [BYTE_W-1:0]    mem_wdata;

  // Address unit for pixel requests; read requests use byte_index directly.
  logic [ADDR_W-1:0]    lin_idx;
  logic [ADDR_W-1:0]    pix_idx;
  logic [2:0]           pix_bit;
  logic                 pix_outside;
  logic                 bidx_outside;
  logic [BYTE_W-1:0]    modified;

  assign s_tready = (state == ST_IDLE);

  assign lin_idx = ADDR_W'(pixel_x) + ADDR_W'(ADDR_W'(pixel_y[COORD_W-1:3]) * WIDTH_A);
  assign pix_idx = flip_mode ? (LAST_IDX - lin_idx) : lin_idx;
  assign pix_bit = flip_mode ? (3'd7 - pixel_y[2:0]) : pixel_y[2:0];
  assign pix_outside  = ({1'b0, pixel_x} >= 9'(PANEL_WIDTH)) ||
                        ({1'b0, pixel_y} >= 9'(PANEL_HEIGHT));
  assign bidx_outside = (32'(byte_index) >= 32'(STORE_BYTES));

  always_comb begin
    unique case (req)
      REQ_INVERT: modified = mem_rdata ^ mask;
      REQ_DRAW:   modified = pixel_colour ? (mem_rdata & ~mask) : (mem_rdata | mask);
      default:    modified = mem_rdata;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = modified;
    unique case (state)
      ST_CLEAR, ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_wdata = fill_byte;
      end
      ST_MODIFY: begin
        mem_we = (req == REQ_DRAW) || (req == REQ_INVERT);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= frame_store[addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (addr == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_LOCATE;
      ST_LOCATE: begin
        unique case (req)
          REQ_FILL:   state_next = ST_SWEEP;
          REQ_READ:   state_next = bidx_outside ? ST_RESP : ST_READ;
          default:    state_next = pix_outside ? ST_RESP : ST_READ;
        endcase
      end
      ST_READ:   state_next = ST_MODIFY;
      ST_MODIFY: state_next = ST_RESP;
      ST_SWEEP:  if (addr == LAST_IDX) state_next = ST_RESP;
      ST_RESP:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      flip_mode         <= 1'b0;
      background_colour <= 1'b0;
      m_tvalid          <= 1'b0;
      addr              <= '0;
      fill_byte         <= FILL_CLEAR;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        priority if (cfg_index == CFG_FLIP_MODE) begin
          flip_mode <= cfg_data;
        end else if (cfg_index == CFG_BACKGROUND) begin
          background_colour <= cfg_data;
        end
      end

      // In the respond step the output register is reloaded below instead.
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR, ST_SWEEP: begin
          addr <= addr + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            req          <= req_type_t'(s_tuser);
            pixel_x      <= s_tdata[7:0];
            pixel_y      <= s_tdata[15:8];
            pixel_colour <= s_tdata[16];
            byte_index   <= s_tdata[26:17];
          end
        end
        ST_LOCATE: begin
          status      <= STATUS_DONE;
          result_data <= '0;
          mask        <= BYTE_W'(1) << pix_bit;
          unique case (req)
            REQ_FILL: begin
              addr      <= '0;
              fill_byte <= background_colour ? FILL_CLEAR : FILL_SET;
            end
            REQ_READ: begin
              addr <= ADDR_W'(byte_index);
              if (bidx_outside) status <= STATUS_ERROR;
            end
            default: begin
              addr <= pix_idx;
              if (pix_outside) status <= STATUS_ERROR;
            end
          endcase
        end
        ST_MODIFY: begin
          if (req == REQ_READ) result_data <= mem_rdata;
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result_data;
            m_tuser  <= status;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/mpf_checker.sv
module mpf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [mpf_pkg::BYTE_W-1:0]        m_tdata,
  input logic                              m_tuser
);
  import mpf_pkg::*;

  // A stalled result keeps its contents.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An error result never carries data.
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_ERROR) |-> (m_tdata == '0))
    else $error("error result with nonzero data");

  // The clearing pass keeps the request side closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_tready && !m_tvalid)
    else $error("block open right after reset");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

endmodule

bind monochrome_page_framebuffer mpf_checker u_mpf_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import mpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct packed {
    logic             status;
    logic [BYTE_W-1:0] read_data;
  } reply_t;

  logic                    clk;
  logic                    rst;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [S_DATA_W-1:0]     s_tdata;
  logic [REQ_W-1:0]        s_tuser;
  logic                    m_tvalid;
  logic                    m_tready;
  logic [BYTE_W-1:0]       m_tdata;
  logic                    m_tuser;
  logic                    cfg_write;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic                    cfg_data;

  monochrome_page_framebuffer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predicted picture and register copies.
  logic [BYTE_W-1:0] frame_image [STORE_BYTES];
  logic              flip_mode;
  logic              background;
  int unsigned       last_pixel_byte;

  reply_t awaited_replies [$];
  reply_t head_reply;

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int checked_count;
  int draw_count;
  int invert_count;
  int fill_count;
  int read_count;
  int outside_count;
  int idle_cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Applies one request to the predicted picture and returns the reply it should give.
  function automatic reply_t frame_apply(input req_type_t req, input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y, input logic colour,
                                         input logic [BIDX_W-1:0] bidx);
    reply_t      r;
    int unsigned lin;
    int unsigned bitpos;
    r.status    = STATUS_DONE;
    r.read_data = '0;
    case (req)
      REQ_DRAW, REQ_INVERT: begin
        if (req == REQ_DRAW) draw_count++;
        else invert_count++;
        if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) begin
          r.status = STATUS_ERROR;
          outside_count++;
        end else begin
          lin    = x + (y / PAGE_ROWS) * PANEL_WIDTH;
          bitpos = y % PAGE_ROWS;
          // An upside-down panel mirrors both the byte order and the rows in a page.
          if (flip_mode) begin
            lin    = STORE_BYTES - 1 - lin;
            bitpos = PAGE_ROWS - 1 - bitpos;
          end
          last_pixel_byte = lin;
          if (req == REQ_INVERT) frame_image[lin][bitpos] = ~frame_image[lin][bitpos];
          else frame_image[lin][bitpos] = (colour == 1'b0);
        end
      end
      REQ_FILL: begin
        fill_count++;
        for (int i = 0; i < STORE_BYTES; i++)
          frame_image[i] = (background == 1'b0) ? FILL_SET : FILL_CLEAR;
      end
      default: begin
        read_count++;
        if (bidx < STORE_BYTES) r.read_data = frame_image[bidx];
        else r.status = STATUS_ERROR;
      end
    endcase
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_request(input req_type_t req, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic colour,
                              input logic [BIDX_W-1:0] bidx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {5'b0, bidx, colour, y, x};
    do @(posedge clk); while (!s_tready);
    awaited_replies.push_back(frame_apply(req, x, y, colour, bidx));
    @(negedge clk);
  endtask

  task automatic drain_replies();
    s_tvalid = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    if (idx == CFG_FLIP_MODE) flip_mode = value;
    else if (idx == CFG_BACKGROUND) background = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic test_cleared_after_reset();
    send_request(REQ_READ, 8'hAA, 8'h55, 1'b1, 10'd0);
    send_request(REQ_READ, 8'h00, 8'h00, 1'b0, 10'd1023);
    send_request(REQ_READ, 8'hFF, 8'hFF, 1'b1, 10'd300);
  endtask

  task automatic test_pixel_requests();
    send_request(REQ_DRAW, 8'd0, 8'd0, 1'b0, 10'h3FF);
    send_request(REQ_DRAW, 8'd127, 8'd63, 1'b0, 10'h000);
    send_request(REQ_READ, 8'd200, 8'd200, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd1023);
    send_request(REQ_INVERT, 8'd0, 8'd1, 1'b1, 10'd17);
    send_request(REQ_DRAW, 8'd0, 8'd0, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd0);
    // Each coordinate just past the panel, then both at their maximum.
    send_request(REQ_DRAW, 8'd128, 8'd0, 1'b0, 10'd0);
    send_request(REQ_INVERT, 8'd0, 8'd64, 1'b0, 10'd0);
    send_request(REQ_DRAW, 8'd255, 8'd255, 1'b1, 10'd0);
  endtask

  task automatic test_fill_and_flip();
    send_request(REQ_FILL, 8'hC3, 8'h3C, 1'b1, 10'h2A5);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd517);
    drain_replies();
    write_register(CFG_FLIP_MODE, 1'b1);
    write_register(CFG_BACKGROUND, 1'b1);
    send_request(REQ_DRAW, 8'd0, 8'd0, 1'b1, 10'd0);
    send_request(REQ_INVERT, 8'd5, 8'd9, 1'b0, 10'd0);
    // Reads are never mirrored, so the raw locations of the last two pixels are read.
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd1023);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd890);
    send_request(REQ_FILL, 8'h00, 8'h00, 1'b0, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd1023);
    send_request(REQ_INVERT, 8'd127, 8'd63, 1'b1, 10'd0);
    send_request(REQ_READ, 8'd0, 8'd0, 1'b0, 10'd0);
    drain_replies();
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                     input logic flip, input logic bg);
    req_type_t             req;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic                  colour;
    logic [BIDX_W-1:0]     bidx;
    int unsigned           pick;
    int unsigned           base_x;
    int unsigned           base_y;
    drain_replies();
    write_register(CFG_FLIP_MODE, flip);
    write_register(CFG_BACKGROUND, bg);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    base_x = 0;
    base_y = 0;
    for (int n = 0; n < count; n++) begin
      // Every field starts with a random value; some are overwritten below, by request kind.
      x      = COORD_W'($urandom_range(0, 255));
      y      = COORD_W'($urandom_range(0, 255));
      colour = 1'($urandom_range(0, 1));
      bidx   = BIDX_W'($urandom_range(0, 1023));
      if (n % 20 == 0) begin
        base_x = $urandom_range(0, PANEL_WIDTH - 4);
        base_y = $urandom_range(0, PANEL_HEIGHT - 16);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        req = REQ_FILL;
      end else if (pick < 33) begin
        req = REQ_READ;
        if ($urandom_range(0, 1) == 0) bidx = last_pixel_byte[BIDX_W-1:0];
      end else begin
        req = ($urandom_range(0, 9) < 6) ? REQ_DRAW : REQ_INVERT;
        pick = $urandom_range(0, 99);
        // A small cluster makes pixels share bytes, so updates build on each other.
        if (pick < 45) begin
          x = COORD_W'(base_x + $urandom_range(0, 3));
          y = COORD_W'(base_y + $urandom_range(0, 15));
        end else if (pick < 90) begin
          x = COORD_W'($urandom_range(0, PANEL_WIDTH - 1));
          y = COORD_W'($urandom_range(0, PANEL_HEIGHT - 1));
        end
      end
      send_request(req, x, y, colour, bidx);
    end
  endtask

  // Result stall pattern.
  always @(negedge clk) m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: result with none expected: status %0d data 0x%02h",
                 $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        head_reply = awaited_replies.pop_front();
        checked_count++;
        if (m_tuser !== head_reply.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, head_reply.status, m_tuser);
          error_count++;
        end
        if (m_tdata !== head_reply.read_data) begin
          $display("%0t: read_data mismatch: expected 0x%02h actual 0x%02h",
                   $time, head_reply.read_data, m_tdata);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, awaited_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = REQ_DRAW;
    cfg_write      = 1'b0;
    cfg_index      = CFG_FLIP_MODE;
    cfg_data       = 1'b0;
    flip_mode      = 1'b0;
    background     = 1'b0;
    last_pixel_byte = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    checked_count  = 0;
    draw_count     = 0;
    invert_count   = 0;
    fill_count     = 0;
    read_count     = 0;
    outside_count  = 0;
    for (int i = 0; i < STORE_BYTES; i++) frame_image[i] = '0;

    repeat (6) @(negedge clk);
    rst = 1'b0;
    // The store is cleared after reset before the first request is taken.
    while (!s_tready) @(negedge clk);

    test_cleared_after_reset();
    test_pixel_requests();
    test_fill_and_flip();
    test_random_traffic(ITEMS_PER_PHASE, 0, 0, 1'b0, 1'b0);
    test_random_traffic(ITEMS_PER_PHASE, 51, 0, 1'b1, 1'b0);
    test_random_traffic(ITEMS_PER_PHASE, 0, 51, 1'b0, 1'b1);
    test_random_traffic(ITEMS_PER_PHASE, 7, 7, 1'b1, 1'b1);
    drain_replies();

    $display("Checked %0d results: %0d draws, %0d inverts, %0d fills, %0d reads, %0d outside",
             checked_count, draw_count, invert_count, fill_count, read_count, outside_count);
    $display("Both flip modes and background colours, with and without idle and stall cycles.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
